/* sv/bsdsa_pkg.sv */
`timescale 1ns / 1ps
// Shared package for the blocked sparse-dense score accumulator.
// Holds sizes, field and command codes and the structs used between modules.
// Depends on nothing.
package bsdsa_pkg;

    // Storage sizes.
    localparam int SAMPLES         = 256;
    localparam int VARIANTS        = 64;
    localparam int SCORES          = 16;
    localparam int EDGES_PER_SCORE = 64;

    localparam int SAMP_W  = $clog2(SAMPLES);
    localparam int VAR_W   = $clog2(VARIANTS);
    localparam int SCORE_W = $clog2(SCORES);
    localparam int EDGE_W  = $clog2(EDGES_PER_SCORE);

    localparam int DOSE_DEPTH = VARIANTS * SAMPLES;
    localparam int EDGE_DEPTH = SCORES * EDGES_PER_SCORE;
    localparam int ACC_DEPTH  = SCORES * SAMPLES;
    localparam int DOSE_AW    = $clog2(DOSE_DEPTH);
    localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
    localparam int ACC_AW     = $clog2(ACC_DEPTH);

    // Field widths.
    localparam int DOSE_W       = 16;
    localparam int WEIGHT_W     = 24;
    localparam int ACC_W        = 48;
    localparam int PROD_W       = WEIGHT_W + DOSE_W + 1;
    localparam int EDGE_ENTRY_W = VAR_W + WEIGHT_W;
    localparam int IDX_W        = 8;

    // Configuration register widths and port.
    localparam int SC_CFG_W   = 9;
    localparam int VC_CFG_W   = 7;
    localparam int NS_CFG_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT_CAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_COUNT  = 2'd2;

    // Item function codes.
    localparam logic [1:0] FN_DOSE  = 2'd0;
    localparam logic [1:0] FN_EDGE  = 2'd1;
    localparam logic [1:0] FN_FLUSH = 2'd2;
    localparam logic [1:0] FN_READ  = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_BAD   = 3'd1;
    localparam logic [2:0] ST_NOVAR = 3'd2;
    localparam logic [2:0] ST_EARLY = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    // Datapath operations issued by the controller.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE      = 5'd0;
    localparam logic [OP_W-1:0] OP_CLR       = 5'd1;
    localparam logic [OP_W-1:0] OP_LATCH     = 5'd2;
    localparam logic [OP_W-1:0] OP_PRE       = 5'd3;
    localparam logic [OP_W-1:0] OP_DOSE      = 5'd4;
    localparam logic [OP_W-1:0] OP_EDGE      = 5'd5;
    localparam logic [OP_W-1:0] OP_FLBEGIN   = 5'd6;
    localparam logic [OP_W-1:0] OP_RDADDR    = 5'd7;
    localparam logic [OP_W-1:0] OP_RDCAP     = 5'd8;
    localparam logic [OP_W-1:0] OP_SCORE     = 5'd9;
    localparam logic [OP_W-1:0] OP_FLEND     = 5'd10;
    localparam logic [OP_W-1:0] OP_EREAD     = 5'd11;
    localparam logic [OP_W-1:0] OP_ELATCH    = 5'd12;
    localparam logic [OP_W-1:0] OP_NEXTSCORE = 5'd13;
    localparam logic [OP_W-1:0] OP_SREAD     = 5'd14;
    localparam logic [OP_W-1:0] OP_MUL       = 5'd15;
    localparam logic [OP_W-1:0] OP_ACCW      = 5'd16;
    localparam logic [OP_W-1:0] OP_NEXTEDGE  = 5'd17;
    localparam logic [OP_W-1:0] OP_RESP      = 5'd18;

    typedef struct packed {
        logic [1:0]                 func;
        logic [DOSE_W-1:0]          dosage;
        logic [IDX_W-1:0]           score_index;
        logic signed [WEIGHT_W-1:0] weight;
        logic [IDX_W-1:0]           sample_index;
    } t_in_item;

    typedef struct packed {
        logic [2:0]              status;
        logic signed [ACC_W-1:0] value;
    } t_out_item;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] func;
        logic       need_flush;
        logic       more_score;
        logic       more_edge;
        logic       more_samp;
        logic       out_busy;
    } t_sts;

endpackage

/* sv/blocked_sparse_dense_score_accumulator_unit.sv */
`timescale 1ns / 1ps
// Top level of the blocked sparse-dense score accumulator.
// Depends on bsdsa_pkg, bsdsa_ctrl and bsdsa_datapath.
//
// Usage:
// Input items arrive on a valid/ready channel; each gives exactly one result
// on the output valid/ready channel, in order. A separate write channel
// sets sample_count, variant_capacity and score_count; it is always ready and
// should only be used while the block is idle.
// After reset the accumulator memory is cleared by a pass over all 4096 entries,
// during which no input transaction is accepted.
// Items are handled one at a time. An edge is decoded, then its result is loaded
// in the response state; a dosage element passes through a write state and a read
// through a capture state before the response. The next item is accepted back
// in idle. A flush (explicit, or triggered by the first element of a vector
// into a full block) walks the active scores and their edges on one shared
// multiply-accumulate unit: for each sample of each edge it reads the dosage and
// the accumulator, multiplies, and writes the saturated sum back.
// The next item is accepted while a result still waits in the output
// register; a stalled receiver holds that result and the block stops before
// loading the following one.
module blocked_sparse_dense_score_accumulator_unit import bsdsa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    bsdsa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (w_sts),
        .o_cmd     (w_cmd)
    );

    // Storage and arithmetic.
    bsdsa_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in       (i_in),
        .i_out_ready(i_out_ready),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

endmodule

/* sv/bsdsa_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module bsdsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/bsdsa_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine: sequences the post-reset clear, item decode, flush walk and response.
// Depends on bsdsa_pkg.
module bsdsa_ctrl import bsdsa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DEC  = 4'd2;
    localparam logic [3:0] S_DW   = 4'd3;
    localparam logic [3:0] S_RD   = 4'd4;
    localparam logic [3:0] S_FSC  = 4'd5;
    localparam logic [3:0] S_FED  = 4'd6;
    localparam logic [3:0] S_FEW  = 4'd7;
    localparam logic [3:0] S_FSM  = 4'd8;
    localparam logic [3:0] S_FMU  = 4'd9;
    localparam logic [3:0] S_FAD  = 4'd10;
    localparam logic [3:0] S_RESP = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and the operation for the datapath.
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_sts.func)
                    FN_DOSE: begin
                        o_cmd.op = OP_PRE;
                        n_state  = i_sts.need_flush ? S_FSC : S_DW;
                    end
                    FN_EDGE: begin
                        o_cmd.op = OP_EDGE;
                        n_state  = S_RESP;
                    end
                    FN_FLUSH: begin
                        o_cmd.op = OP_FLBEGIN;
                        n_state  = S_FSC;
                    end
                    default: begin
                        o_cmd.op = OP_RDADDR;
                        n_state  = S_RD;
                    end
                endcase
            end
            S_DW: begin
                o_cmd.op = OP_DOSE;
                n_state  = S_RESP;
            end
            S_RD: begin
                o_cmd.op = OP_RDCAP;
                n_state  = S_RESP;
            end
            S_FSC: begin
                if (i_sts.more_score) begin
                    o_cmd.op = OP_SCORE;
                    n_state  = S_FED;
                end else begin
                    o_cmd.op = OP_FLEND;
                    n_state  = (i_sts.func == FN_DOSE) ? S_DW : S_RESP;
                end
            end
            S_FED: begin
                if (i_sts.more_edge) begin
                    o_cmd.op = OP_EREAD;
                    n_state  = S_FEW;
                end else begin
                    o_cmd.op = OP_NEXTSCORE;
                    n_state  = S_FSC;
                end
            end
            S_FEW: begin
                o_cmd.op = OP_ELATCH;
                n_state  = S_FSM;
            end
            S_FSM: begin
                if (i_sts.more_samp) begin
                    o_cmd.op = OP_SREAD;
                    n_state  = S_FMU;
                end else begin
                    o_cmd.op = OP_NEXTEDGE;
                    n_state  = S_FED;
                end
            end
            S_FMU: begin
                o_cmd.op = OP_MUL;
                n_state  = S_FAD;
            end
            S_FAD: begin
                o_cmd.op = OP_ACCW;
                n_state  = S_FSM;
            end
            S_RESP: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_RESP;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/bsdsa_datapath.sv */
`timescale 1ns / 1ps
// Datapath: configuration, block bookkeeping, the three memories, the
// multiply-accumulate with saturation and the output register.
// Depends on bsdsa_pkg and bsdsa_ram.
module bsdsa_datapath import bsdsa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  t_in_item              i_in,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration.
    logic [SC_CFG_W-1:0] r_sc;
    logic [VC_CFG_W-1:0] r_cap;
    logic [NS_CFG_W-1:0] r_ns;

    // Block bookkeeping.
    t_in_item            r_item;
    logic [EDGE_W:0]     r_edge_cnt [SCORES];
    logic [SCORE_W-1:0]  r_active [SCORES];
    logic [SCORE_W:0]    r_ac;
    logic [VAR_W:0]      r_vc;
    logic [SAMP_W-1:0]   r_pos;
    logic                r_has;
    logic [ACC_AW-1:0]   r_clr;

    // Flush walk.
    logic [SCORE_W:0]           r_a;
    logic [EDGE_W:0]            r_e;
    logic [EDGE_W:0]            r_n;
    logic [SAMP_W:0]            r_i;
    logic [SCORE_W-1:0]         r_s;
    logic [VAR_W-1:0]           r_slot;
    logic signed [WEIGHT_W-1:0] r_weight;
    logic signed [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]           r_acc_old;

    // Result.
    logic [2:0]       r_status;
    logic [ACC_W-1:0] r_value;
    logic             r_rd_ok;
    logic             r_out_valid;
    t_out_item        r_out;

    // Memory ports.
    logic [DOSE_W-1:0]       w_dose_rdata;
    logic [EDGE_ENTRY_W-1:0] w_edge_rdata;
    logic [ACC_W-1:0]        w_acc_rdata;
    logic                    w_acc_we;
    logic [ACC_AW-1:0]       w_acc_waddr;
    logic [ACC_W-1:0]        w_acc_wdata;
    logic [ACC_AW-1:0]       w_acc_raddr;

    // Decode helpers.
    logic                       w_drop;
    logic [VAR_W:0]             w_vc_eff;
    logic [SCORE_W-1:0]         w_sidx;
    logic [EDGE_W:0]            w_cnt;
    logic                       w_bad_score;
    logic [2:0]                 w_edge_st;
    logic                       w_rd_ok;
    logic [SAMP_W:0]            w_pos_inc;
    logic [VAR_W-1:0]           w_new_slot;
    logic [SCORE_W-1:0]         w_act_s;
    logic signed [PROD_W-1:0]   w_prod;
    logic [ACC_W:0]             w_sum;
    logic [ACC_W-1:0]           w_sat;

    assign o_cfg_ready = 1'b1;

    // Edgeless-variant drop and the automatic flush test.
    assign w_drop   = (r_pos == '0) && (r_vc != '0) && !r_has;
    assign w_vc_eff = r_vc - (VAR_W + 1)'(w_drop);

    // Edge and read checks.
    assign w_sidx      = r_item.score_index[SCORE_W-1:0];
    assign w_cnt       = r_edge_cnt[w_sidx];
    assign w_bad_score = r_item.score_index >= {{(IDX_W - NS_CFG_W){1'b0}}, r_ns};
    assign w_rd_ok     = !w_bad_score && ({1'b0, r_item.sample_index} < r_sc);
    assign w_pos_inc   = {1'b0, r_pos} + (SAMP_W + 1)'(1);
    assign w_new_slot  = VAR_W'(r_vc - (VAR_W + 1)'(1));
    assign w_act_s     = r_active[r_a[SCORE_W-1:0]];

    always_comb begin
        if (w_bad_score) begin
            w_edge_st = ST_BAD;
        end else if (r_vc == '0 || r_pos != '0) begin
            w_edge_st = ST_EARLY;
        end else if (w_cnt >= (EDGE_W + 1)'(EDGES_PER_SCORE)) begin
            w_edge_st = ST_FULL;
        end else begin
            w_edge_st = ST_OK;
        end
    end

    // Product of the edge weight and the dosage, then saturating add.
    assign w_prod = r_weight * $signed({1'b0, w_dose_rdata});
    assign w_sum  = {r_acc_old[ACC_W-1], r_acc_old}
                  + {{(ACC_W + 1 - PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sat = w_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            w_sat = w_sum[ACC_W-1:0];
        end
    end

    // Status towards the controller.
    assign o_sts.clr_done   = (r_clr == ACC_AW'(ACC_DEPTH - 1));
    assign o_sts.func       = r_item.func;
    assign o_sts.need_flush = (r_pos == '0) && (w_vc_eff >= r_cap);
    assign o_sts.more_score = r_a < r_ac;
    assign o_sts.more_edge  = r_e < r_n;
    assign o_sts.more_samp  = r_i < r_sc;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    // Dosage store.
    bsdsa_ram #(.WIDTH(DOSE_W), .DEPTH(DOSE_DEPTH)) u_dose_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.op == OP_DOSE),
        .i_waddr({r_vc[VAR_W-1:0], r_pos}),
        .i_wdata(r_item.dosage),
        .i_raddr({r_slot, r_i[SAMP_W-1:0]}),
        .o_rdata(w_dose_rdata)
    );

    // Edge store: slot and weight per entry.
    bsdsa_ram #(.WIDTH(EDGE_ENTRY_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   ((i_cmd.op == OP_EDGE) && (w_edge_st == ST_OK)),
        .i_waddr({w_sidx, w_cnt[EDGE_W-1:0]}),
        .i_wdata({w_new_slot, r_item.weight}),
        .i_raddr({r_s, r_e[EDGE_W-1:0]}),
        .o_rdata(w_edge_rdata)
    );

    // Accumulator store, cleared by a pass after reset.
    assign w_acc_we    = (i_cmd.op == OP_CLR) || (i_cmd.op == OP_ACCW);
    assign w_acc_waddr = (i_cmd.op == OP_CLR) ? r_clr : {r_s, r_i[SAMP_W-1:0]};
    assign w_acc_wdata = (i_cmd.op == OP_CLR) ? '0 : w_sat;
    assign w_acc_raddr = (i_cmd.op == OP_RDADDR)
                       ? {w_sidx, r_item.sample_index[SAMP_W-1:0]}
                       : {r_s, r_i[SAMP_W-1:0]};

    bsdsa_ram #(.WIDTH(ACC_W), .DEPTH(ACC_DEPTH)) u_acc_ram (
        .i_clk  (i_clk),
        .i_we   (w_acc_we),
        .i_waddr(w_acc_waddr),
        .i_wdata(w_acc_wdata),
        .i_raddr(w_acc_raddr),
        .o_rdata(w_acc_rdata)
    );

    // Control state: configuration, counts, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc        <= SC_CFG_W'(SAMPLES);
            r_cap       <= VC_CFG_W'(VARIANTS);
            r_ns        <= NS_CFG_W'(SCORES);
            r_ac        <= '0;
            r_vc        <= '0;
            r_pos       <= '0;
            r_has       <= 1'b1;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < SCORES; k++) begin
                r_edge_cnt[k] <= '0;
            end
        end else begin
            // Configuration writes, clamped to the legal range.
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SAMPLE_COUNT: begin
                        if (i_cfg_data == '0) r_sc <= SC_CFG_W'(1);
                        else if (i_cfg_data > SC_CFG_W'(SAMPLES)) r_sc <= SC_CFG_W'(SAMPLES);
                        else r_sc <= i_cfg_data;
                    end
                    CFG_VARIANT_CAP: begin
                        if (i_cfg_data[VC_CFG_W-1:0] == '0) r_cap <= VC_CFG_W'(1);
                        else if (i_cfg_data[VC_CFG_W-1:0] > VC_CFG_W'(VARIANTS))
                            r_cap <= VC_CFG_W'(VARIANTS);
                        else r_cap <= i_cfg_data[VC_CFG_W-1:0];
                    end
                    CFG_SCORE_COUNT: begin
                        if (i_cfg_data[NS_CFG_W-1:0] == '0) r_ns <= NS_CFG_W'(1);
                        else if (i_cfg_data[NS_CFG_W-1:0] > NS_CFG_W'(SCORES))
                            r_ns <= NS_CFG_W'(SCORES);
                        else r_ns <= i_cfg_data[NS_CFG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            // Block bookkeeping driven by the controller.
            unique case (i_cmd.op)
                OP_CLR: begin
                    r_clr <= r_clr + ACC_AW'(1);
                end
                OP_PRE: begin
                    if (w_drop) begin
                        r_vc  <= w_vc_eff;
                        r_has <= 1'b1;
                    end
                end
                OP_DOSE: begin
                    if (w_pos_inc >= r_sc) begin
                        r_pos <= '0;
                        r_vc  <= r_vc + (VAR_W + 1)'(1);
                        r_has <= 1'b0;
                    end else begin
                        r_pos <= w_pos_inc[SAMP_W-1:0];
                    end
                end
                OP_EDGE: begin
                    if (w_edge_st == ST_OK) begin
                        if (w_cnt == '0 && r_ac < (SCORE_W + 1)'(SCORES)) begin
                            r_ac <= r_ac + (SCORE_W + 1)'(1);
                        end
                        r_edge_cnt[w_sidx] <= w_cnt + (EDGE_W + 1)'(1);
                        r_has <= 1'b1;
                    end
                end
                OP_FLEND: begin
                    for (int k = 0; k < SCORES; k++) begin
                        r_edge_cnt[k] <= '0;
                    end
                    r_ac  <= '0;
                    r_vc  <= '0;
                    r_pos <= '0;
                    r_has <= 1'b1;
                end
                default: begin
                end
            endcase

            // Output register: loads a result, empties on a taken transaction.
            if (i_cmd.op == OP_RESP) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_item   <= i_in;
                r_status <= ST_OK;
                r_value  <= '0;
            end
            OP_PRE: begin
                r_a <= '0;
                if (w_drop) r_status <= ST_NOVAR;
            end
            OP_EDGE: begin
                r_status <= w_edge_st;
                if (w_edge_st == ST_OK && w_cnt == '0 && r_ac < (SCORE_W + 1)'(SCORES)) begin
                    r_active[r_ac[SCORE_W-1:0]] <= w_sidx;
                end
            end
            OP_FLBEGIN: begin
                r_a <= '0;
                if (r_vc != '0 && !r_has) r_status <= ST_NOVAR;
            end
            OP_RDADDR: begin
                r_status <= w_bad_score ? ST_BAD : ST_OK;
                r_rd_ok  <= w_rd_ok;
            end
            OP_RDCAP: begin
                r_value <= r_rd_ok ? w_acc_rdata : '0;
            end
            OP_SCORE: begin
                r_s <= w_act_s;
                r_n <= r_edge_cnt[w_act_s];
                r_e <= '0;
            end
            OP_NEXTSCORE: begin
                r_a <= r_a + (SCORE_W + 1)'(1);
            end
            OP_ELATCH: begin
                r_slot   <= w_edge_rdata[EDGE_ENTRY_W-1:WEIGHT_W];
                r_weight <= w_edge_rdata[WEIGHT_W-1:0];
                r_i      <= '0;
            end
            OP_MUL: begin
                r_prod    <= w_prod;
                r_acc_old <= w_acc_rdata;
            end
            OP_ACCW: begin
                r_i <= r_i + (SAMP_W + 1)'(1);
            end
            OP_NEXTEDGE: begin
                r_e <= r_e + (EDGE_W + 1)'(1);
            end
            OP_RESP: begin
                r_out.status <= r_status;
                r_out.value  <= r_value;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The active list never holds more scores than exist.
    a_ac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ac <= (SCORE_W + 1)'(SCORES))
        else $error("active score count out of range");

    // The variant count stays within the block.
    a_vc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vc <= (VAR_W + 1)'(VARIANTS))
        else $error("variant count out of range");

    // The end of a flush leaves an empty block.
    a_flush_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_FLEND |=> (r_vc == '0) && (r_pos == '0) && (r_ac == '0) && r_has)
        else $error("block not empty after flush");

    // A new result is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_RESP |-> !r_out_valid || i_out_ready)
        else $error("result overwritten before it was taken");

endmodule
